// File: design/mcr_pkg.sv
// Shared constants for the midpoint circle rasterizer.
package mcr_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int RADIUS_BITS_DEF = 14;
  localparam int QUEUE_DEPTH_DEF = 2;

  // request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // fill_mode values
  localparam logic MODE_OUTLINE = 1'b0;
  localparam logic MODE_FILL    = 1'b1;

  // segment sequencing
  localparam int          SEG_W            = 3;
  localparam logic [2:0]  LAST_SEG_OUTLINE = 3'd7;
  localparam logic [2:0]  LAST_SEG_FILL    = 3'd3;

endpackage

// File: design/midpoint_circle_rasterizer_core.sv
// Results: a step request is written into the job queue, then each of its results into the
// result queue, from whose head the out_ ports read and out_pop takes them.
// Throughput: one result per cycle while the result queue has room; a step occupies the
// segment sequencer for 8 segments (outline) or 4 (filled), which sets the sustained rate of step requests.
// Requests are taken every cycle while the 2-entry job queue has room; start requests
// produce no result. Reset (rst_n low, synchronous) empties both queues, makes the
// circle idle and clears fill_mode to outline.
module midpoint_circle_rasterizer_core #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_op,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [COORD_BITS:0]    out_x_start,
  output logic signed [COORD_BITS:0]    out_y_start,
  output logic signed [COORD_BITS:0]    out_x_end,
  output logic signed [COORD_BITS:0]    out_y_end,
  output logic                          out_last,
  output logic                          out_done_res
);

  localparam int JOB_W = 2*COORD_BITS + 2*(RADIUS_BITS + 2) + 2;
  localparam int OUT_W = COORD_BITS + 1;
  localparam int RES_W = 4*OUT_W + 2;

  logic             jq_push, jq_full, jq_pop, jq_empty;
  logic [JOB_W-1:0] jq_wdata, jq_rdata;
  logic             oq_push, oq_full;
  logic [RES_W-1:0] oq_wdata, oq_rdata;

  mcr_front #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_op      (in_op),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius  (in_radius),
    .jq_push    (jq_push),
    .jq_wdata   (jq_wdata),
    .jq_full    (jq_full)
  );

  mcr_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_jobq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (jq_push),
    .wdata(jq_wdata),
    .full (jq_full),
    .pop  (jq_pop),
    .rdata(jq_rdata),
    .empty(jq_empty)
  );

  mcr_back #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .jq_empty(jq_empty),
    .jq_rdata(jq_rdata),
    .jq_pop  (jq_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_wdata(oq_wdata)
  );

  mcr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_resq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (oq_push),
    .wdata(oq_wdata),
    .full (oq_full),
    .pop  (out_pop),
    .rdata(oq_rdata),
    .empty(out_empty)
  );

  assign out_x_start  = oq_rdata[RES_W-1 -: OUT_W];
  assign out_y_start  = oq_rdata[RES_W-1-OUT_W -: OUT_W];
  assign out_x_end    = oq_rdata[RES_W-1-2*OUT_W -: OUT_W];
  assign out_y_end    = oq_rdata[RES_W-1-3*OUT_W -: OUT_W];
  assign out_last     = oq_rdata[1];
  assign out_done_res = oq_rdata[0];

endmodule

// File: design/mcr_fifo.sv
// Small synchronous queue with registered storage.
module mcr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  // DEPTH must be a power of two so the pointers wrap on their own
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: design/mcr_front.sv
// Front end: takes requests, keeps the circle walk state, queues step jobs.
module mcr_front #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_op,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius,
  output logic                          jq_push,
  output logic [2*COORD_BITS+2*(RADIUS_BITS+2)+1:0] jq_wdata,
  input  logic                          jq_full
);

  localparam int O_W = RADIUS_BITS + 2;   // offsets, signed: y drops below zero on radius 0
  localparam int D_W = RADIUS_BITS + 4;   // decision value

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [RADIUS_BITS-1:0]       r_r;
  logic signed [O_W-1:0]        ox_r, oy_r, ox_nxt, oy_nxt;
  logic signed [D_W-1:0]        d_r, d_nxt;
  logic                         active_r, fill_r;

  logic                         acc, is_step, can_step, done_nxt;
  logic signed [D_W-1:0]        ox_d, oy_d, r_d, tw_ox, tw_oy;

  assign in_full  = jq_full;
  assign acc      = in_push && !jq_full;
  assign is_step  = (in_op == mcr_pkg::OP_STEP);
  assign can_step = active_r && !(oy_r < ox_r);

  assign ox_d  = D_W'(ox_r);
  assign oy_d  = D_W'(oy_r);
  assign r_d   = D_W'($signed({1'b0, r_r}));
  assign tw_ox = ox_d <<< 1;
  assign tw_oy = oy_d <<< 1;

  always_comb begin
    if (d_r >= tw_ox) begin
      d_nxt  = D_W'(d_r - tw_ox - 1);
      ox_nxt = O_W'(ox_r + 1);
      oy_nxt = oy_r;
    end else if (d_r < ((r_d - oy_d) <<< 1)) begin
      d_nxt  = D_W'(d_r + tw_oy - 1);
      ox_nxt = ox_r;
      oy_nxt = O_W'(oy_r - 1);
    end else begin
      d_nxt  = D_W'(d_r + tw_oy - tw_ox - 2);
      ox_nxt = O_W'(ox_r + 1);
      oy_nxt = O_W'(oy_r - 1);
    end
  end

  assign done_nxt = (oy_nxt < ox_nxt);
  assign jq_push  = acc && is_step && can_step;
  assign jq_wdata = {cx_r, cy_r, ox_r, oy_r, fill_r, done_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fill_r   <= mcr_pkg::MODE_OUTLINE;
    end else begin
      if (cfg_we) begin
        fill_r <= cfg_wdata;
      end
      if (acc) begin
        if (!is_step) begin
          active_r <= 1'b1;
        end else if (can_step) begin
          active_r <= !done_nxt;
        end else begin
          active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (!is_step) begin
        cx_r <= in_center_x;
        cy_r <= in_center_y;
        r_r  <= in_radius;
        ox_r <= '0;
        oy_r <= O_W'({1'b0, in_radius});
        d_r  <= D_W'($signed({1'b0, in_radius}) - 1);
      end else if (can_step) begin
        ox_r <= ox_nxt;
        oy_r <= oy_nxt;
        d_r  <= d_nxt;
      end
    end
  end

  a_push_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    jq_push |-> (active_r && !(oy_r < ox_r)))
    else $error("step job queued without a running circle");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (jq_push && done_nxt) |=> !active_r)
    else $error("circle still active after final step");

endmodule

// File: design/mcr_back.sv
// Back end: expands one step job into its outline points or filled spans.
module mcr_back #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          jq_empty,
  input  logic [2*COORD_BITS+2*(RADIUS_BITS+2)+1:0] jq_rdata,
  output logic                          jq_pop,
  input  logic                          oq_full,
  output logic                          oq_push,
  output logic [4*(COORD_BITS+1)+1:0]   oq_wdata
);

  localparam int O_W   = RADIUS_BITS + 2;
  localparam int OUT_W = COORD_BITS + 1;
  localparam int S_W   = ((COORD_BITS > O_W) ? COORD_BITS : O_W) + 1;
  localparam int OY_LO = 2;
  localparam int OX_LO = OY_LO + O_W;
  localparam int CY_LO = OX_LO + O_W;
  localparam int CX_LO = CY_LO + COORD_BITS;

  logic signed [COORD_BITS-1:0]  cx, cy;
  logic signed [O_W-1:0]         ox, oy;
  logic                          fill, done;
  logic [mcr_pkg::SEG_W-1:0]     k_r, last_k;
  logic                          seg_last;
  logic signed [S_W-1:0]         x_po, x_mo, x_py, x_my, y_po, y_mo, y_py, y_my;
  logic [OUT_W-1:0]              xs, ys, xe, ye;

  assign done = jq_rdata[0];
  assign fill = jq_rdata[1];
  assign oy   = jq_rdata[OX_LO-1:OY_LO];
  assign ox   = jq_rdata[CY_LO-1:OX_LO];
  assign cy   = jq_rdata[CX_LO-1:CY_LO];
  assign cx   = jq_rdata[CX_LO+COORD_BITS-1:CX_LO];

  // x_po = cx + ox, x_my = cx - oy, y_py = cy + oy, ...
  assign x_po = S_W'(cx) + S_W'(ox);
  assign x_mo = S_W'(cx) - S_W'(ox);
  assign x_py = S_W'(cx) + S_W'(oy);
  assign x_my = S_W'(cx) - S_W'(oy);
  assign y_po = S_W'(cy) + S_W'(ox);
  assign y_mo = S_W'(cy) - S_W'(ox);
  assign y_py = S_W'(cy) + S_W'(oy);
  assign y_my = S_W'(cy) - S_W'(oy);

  assign last_k   = (fill == mcr_pkg::MODE_FILL) ? mcr_pkg::LAST_SEG_FILL
                                                 : mcr_pkg::LAST_SEG_OUTLINE;
  assign seg_last = (k_r == last_k);
  assign oq_push  = !jq_empty && !oq_full;
  assign jq_pop   = oq_push && seg_last;

  always_comb begin
    xs = x_po[OUT_W-1:0];
    ys = y_py[OUT_W-1:0];
    xe = x_po[OUT_W-1:0];
    ye = y_py[OUT_W-1:0];
    if (fill == mcr_pkg::MODE_FILL) begin
      case (k_r[1:0])
        2'd0: begin
          xs = x_my[OUT_W-1:0]; ys = y_po[OUT_W-1:0];
          xe = x_py[OUT_W-1:0]; ye = y_po[OUT_W-1:0];
        end
        2'd1: begin
          xs = x_mo[OUT_W-1:0]; ys = y_py[OUT_W-1:0];
          xe = x_po[OUT_W-1:0]; ye = y_py[OUT_W-1:0];
        end
        2'd2: begin
          xs = x_mo[OUT_W-1:0]; ys = y_my[OUT_W-1:0];
          xe = x_po[OUT_W-1:0]; ye = y_my[OUT_W-1:0];
        end
        default: begin
          xs = x_my[OUT_W-1:0]; ys = y_mo[OUT_W-1:0];
          xe = x_py[OUT_W-1:0]; ye = y_mo[OUT_W-1:0];
        end
      endcase
    end else begin
      case (k_r)
        3'd0:    begin xs = x_po[OUT_W-1:0]; ys = y_py[OUT_W-1:0]; end
        3'd1:    begin xs = x_py[OUT_W-1:0]; ys = y_po[OUT_W-1:0]; end
        3'd2:    begin xs = x_mo[OUT_W-1:0]; ys = y_py[OUT_W-1:0]; end
        3'd3:    begin xs = x_my[OUT_W-1:0]; ys = y_po[OUT_W-1:0]; end
        3'd4:    begin xs = x_po[OUT_W-1:0]; ys = y_my[OUT_W-1:0]; end
        3'd5:    begin xs = x_py[OUT_W-1:0]; ys = y_mo[OUT_W-1:0]; end
        3'd6:    begin xs = x_mo[OUT_W-1:0]; ys = y_my[OUT_W-1:0]; end
        default: begin xs = x_my[OUT_W-1:0]; ys = y_mo[OUT_W-1:0]; end
      endcase
      xe = xs;
      ye = ys;
    end
  end

  assign oq_wdata = {xs, ys, xe, ye, seg_last, done && seg_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (oq_push) begin
      if (seg_last) begin
        k_r <= '0;
      end else begin
        k_r <= k_r + mcr_pkg::SEG_W'(1);
      end
    end
  end

  a_mid_job_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != '0) |-> !jq_empty)
    else $error("segment counter running with no job at the head");

  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !jq_empty |-> (k_r <= last_k))
    else $error("segment counter past the last segment of the job");

endmodule

// File: tb/midpoint_circle_rasterizer_core_test.sv
// Self-checking testbench for the midpoint circle rasterizer core.
module midpoint_circle_rasterizer_core_test;

  localparam int COORD_BITS  = mcr_pkg::COORD_BITS_DEF;
  localparam int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF;
  // ~370 requests, up to 8 segments each, stalled receiver and sender gaps:
  // the limit leaves a wide margin for a clean run.
  localparam int CYCLE_LIMIT   = 400000;
  // idle cycles after the last segment before a config write or the end;
  // covers the result latency plus any result-less requests still queued
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 40;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    logic [COORD_BITS:0] xs;
    logic [COORD_BITS:0] ys;
    logic [COORD_BITS:0] xe;
    logic [COORD_BITS:0] ye;
    logic                last;
    logic                done;
  } seg_t;

  // directed row: n < 0 means use the predictor, otherwise exactly n
  // segments, each the point (cx, cy), the final one marked last and done
  typedef struct packed {
    logic mode;
    logic op;
    int   cx;
    int   cy;
    int   r;
    int   n;
  } row_t;

  localparam int NUM_ROWS = 25;
  localparam row_t PLAN [NUM_ROWS] = '{
    // step right after reset
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     0},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_START, 32767,  -32768, 0,     -1},
    // zero radius: center only
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  32767,  -32768, 0,     8},
    // circle already finished
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     0},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_START, -32768, 32767,  16383, -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    // restart while active
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_START, 100,    -200,   5,     -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_START, 32767,  32767,  16383, -1},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_START, -32768, -32768, 0,     -1},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_STEP,  -32768, -32768, 0,     4},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_START, 0,      0,      3,     -1},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    // mode flips mid-circle
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_OUTLINE, mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_STEP,  0,      0,      0,     -1},
    '{mcr_pkg::MODE_FILL,    mcr_pkg::OP_STEP,  0,      0,      0,     -1}
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic                         cfg_wdata = 1'b0;
  logic                         in_push = 1'b0;
  logic                         in_full;
  logic                         in_op = mcr_pkg::OP_START;
  logic signed [COORD_BITS-1:0] in_center_x = '0;
  logic signed [COORD_BITS-1:0] in_center_y = '0;
  logic [RADIUS_BITS-1:0]       in_radius = '0;
  logic                         out_empty;
  logic                         out_pop = 1'b0;
  logic signed [COORD_BITS:0]   out_x_start;
  logic signed [COORD_BITS:0]   out_y_start;
  logic signed [COORD_BITS:0]   out_x_end;
  logic signed [COORD_BITS:0]   out_y_end;
  logic                         out_last;
  logic                         out_done_res;

  midpoint_circle_rasterizer_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_op        (in_op),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius    (in_radius),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_x_start  (out_x_start),
    .out_y_start  (out_y_start),
    .out_x_end    (out_x_end),
    .out_y_end    (out_y_end),
    .out_last     (out_last),
    .out_done_res (out_done_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // circle walk state as the block should hold it
  int   circ_cx, circ_cy, circ_r, off_x, off_y, decision;
  bit   circ_on = 1'b0;
  logic fill_now = mcr_pkg::MODE_OUTLINE;

  seg_t step_segs[$];
  seg_t pending_segs[$];

  int   cycle_count = 0;
  int   errors = 0;
  int   segs_checked = 0;
  int   circles_done = 0;
  int   starts_sent = 0;
  int   steps_sent = 0;
  int   useful_requests = 0;
  int   burst_left = 0;
  int   max_gap = 0;
  int   stall_period = 4;
  int   stall_len = 0;
  seg_t got_seg, want_seg;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[cycle %0d] mismatch: %s", cycle_count, what);
  endtask

  function automatic void add_seg(input int xs, input int ys, input int xe, input int ye,
                                  input bit tail);
    seg_t s;
    s.xs   = xs[COORD_BITS:0];
    s.ys   = ys[COORD_BITS:0];
    s.xe   = xe[COORD_BITS:0];
    s.ye   = ye[COORD_BITS:0];
    s.last = tail;
    s.done = tail && !circ_on;
    step_segs.push_back(s);
  endfunction

  // advances the predicted walk by one request and leaves its segments in step_segs
  function automatic void walk_circle(input logic op, input logic [COORD_BITS-1:0] cx,
                                      input logic [COORD_BITS-1:0] cy,
                                      input logic [RADIUS_BITS-1:0] r);
    int ox, oy;
    step_segs.delete();
    if (op == mcr_pkg::OP_START) begin
      circ_cx  = $signed(cx);
      circ_cy  = $signed(cy);
      circ_r   = r;
      off_x    = 0;
      off_y    = circ_r;
      decision = circ_r - 1;
      circ_on  = 1'b1;
      return;
    end
    if (!circ_on || off_y < off_x) begin
      circ_on = 1'b0;
      return;
    end
    ox = off_x;
    oy = off_y;
    if (decision >= 2 * off_x) begin
      decision -= 2 * off_x + 1;
      off_x++;
    end else if (decision < 2 * (circ_r - off_y)) begin
      decision += 2 * off_y - 1;
      off_y--;
    end else begin
      decision += 2 * (off_y - off_x - 1);
      off_y--;
      off_x++;
    end
    if (off_y < off_x) circ_on = 1'b0;
    if (fill_now == mcr_pkg::MODE_OUTLINE) begin
      add_seg(circ_cx + ox, circ_cy + oy, circ_cx + ox, circ_cy + oy, 1'b0);
      add_seg(circ_cx + oy, circ_cy + ox, circ_cx + oy, circ_cy + ox, 1'b0);
      add_seg(circ_cx - ox, circ_cy + oy, circ_cx - ox, circ_cy + oy, 1'b0);
      add_seg(circ_cx - oy, circ_cy + ox, circ_cx - oy, circ_cy + ox, 1'b0);
      add_seg(circ_cx + ox, circ_cy - oy, circ_cx + ox, circ_cy - oy, 1'b0);
      add_seg(circ_cx + oy, circ_cy - ox, circ_cx + oy, circ_cy - ox, 1'b0);
      add_seg(circ_cx - ox, circ_cy - oy, circ_cx - ox, circ_cy - oy, 1'b0);
      add_seg(circ_cx - oy, circ_cy - ox, circ_cx - oy, circ_cy - ox, 1'b1);
    end else begin
      add_seg(circ_cx - oy, circ_cy + ox, circ_cx + oy, circ_cy + ox, 1'b0);
      add_seg(circ_cx - ox, circ_cy + oy, circ_cx + ox, circ_cy + oy, 1'b0);
      add_seg(circ_cx - ox, circ_cy - oy, circ_cx + ox, circ_cy - oy, 1'b0);
      add_seg(circ_cx - oy, circ_cy - ox, circ_cx + oy, circ_cy - ox, 1'b1);
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return COORD_BITS'($urandom_range(0, 65535));
  endfunction

  // sends one request in the current burst and queues what it should produce
  task automatic issue(input logic op, input logic [COORD_BITS-1:0] cx,
                       input logic [COORD_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] r,
                       input int typed_n);
    int   gap;
    seg_t seg;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_push     <= 1'b1;
    in_op       <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius   <= r;
    do @(posedge clk); while (in_full);
    walk_circle(op, cx, cy, r);
    if (op == mcr_pkg::OP_START) starts_sent++;
    else steps_sent++;
    if (op == mcr_pkg::OP_START || step_segs.size() != 0) useful_requests++;
    if (typed_n >= 0) begin
      for (int i = 0; i < typed_n; i++) begin
        seg.xs   = {cx[COORD_BITS-1], cx};
        seg.ys   = {cy[COORD_BITS-1], cy};
        seg.xe   = {cx[COORD_BITS-1], cx};
        seg.ye   = {cy[COORD_BITS-1], cy};
        seg.last = (i == typed_n - 1);
        seg.done = (i == typed_n - 1);
        pending_segs.push_back(seg);
      end
    end else begin
      foreach (step_segs[i]) pending_segs.push_back(step_segs[i]);
    end
  endtask

  task automatic settle();
    in_push <= 1'b0;
    burst_left = 0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    fill_now = mode;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached with %0d segments pending",
               CYCLE_LIMIT, pending_segs.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stalls on a repeating window that the stimulus reshapes per phase
  always @(posedge clk)
    out_pop <= (stall_len == 0) || ((cycle_count % stall_period) >= stall_len);

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      got_seg = {out_x_start, out_y_start, out_x_end, out_y_end, out_last, out_done_res};
      segs_checked++;
      if (got_seg.done) circles_done++;
      if (pending_segs.size() == 0) begin
        report_mismatch($sformatf("unexpected segment (%0d,%0d)->(%0d,%0d) last=%0b done=%0b",
                        out_x_start, out_y_start, out_x_end, out_y_end,
                        out_last, out_done_res));
      end else begin
        want_seg = pending_segs.pop_front();
        if (got_seg !== want_seg)
          report_mismatch($sformatf(
            "got (%0d,%0d)->(%0d,%0d) l%0b d%0b want (%0d,%0d)->(%0d,%0d) l%0b d%0b",
            out_x_start, out_y_start, out_x_end, out_y_end, out_last, out_done_res,
            $signed(want_seg.xs), $signed(want_seg.ys), $signed(want_seg.xe),
            $signed(want_seg.ye), want_seg.last, want_seg.done));
      end
    end
  end

  initial begin
    int phase_base, r, est, k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].mode != fill_now) write_mode(PLAN[i].mode);
      issue(PLAN[i].op, PLAN[i].cx[COORD_BITS-1:0], PLAN[i].cy[COORD_BITS-1:0],
            PLAN[i].r[RADIUS_BITS-1:0], PLAN[i].n);
    end

    // random phases: mostly whole circles with random content, some stray requests
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(ph < 2 ? ph[0] : logic'($urandom_range(0, 1)));
      stall_period = $urandom_range(2, 9);
      stall_len    = (ph == 1) ? 0 : $urandom_range(0, stall_period - 1);
      max_gap      = (ph == 2) ? 0 : $urandom_range(1, 6);
      phase_base   = useful_requests;
      while (useful_requests - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          issue(logic'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                RADIUS_BITS'($urandom_range(0, 40)), -1);
        end else begin
          r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 24);
          issue(mcr_pkg::OP_START, pick_coord(), pick_coord(), RADIUS_BITS'(r), -1);
          est = r * 3 / 4 + 2;
          if (est > 30) est = 30;
          k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, est) : est + $urandom_range(0, 2);
          repeat (k) issue(mcr_pkg::OP_STEP, COORD_BITS'($urandom_range(0, 65535)),
                           COORD_BITS'($urandom_range(0, 65535)),
                           RADIUS_BITS'($urandom_range(0, 16383)), -1);
        end
      end
    end

    settle();
    $display("Ran %0d start and %0d step requests over %0d random phases in both fill modes,",
             starts_sent, steps_sent, NUM_PHASES);
    $display("checked %0d segments, %0d circles walked to completion, %0d mismatches.",
             segs_checked, circles_done, errors);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
